>>> rtl/core/tes_pkg.sv
// Types, codes and microcode ROM shared by the timed event slot table.
package tes_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_WAKE = 1'b1;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_LIGHT = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  light_number;
    logic [31:0] minute_value;
    logic        switch_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       accepted;
    logic [7:0] command_light;
    logic       command_on;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0]  light;
    logic [31:0] minute;
    logic        turn_on;
  } slot_t;

  typedef enum logic [2:0] {
    STEP_IDLE      = 3'd0,
    STEP_DISPATCH  = 3'd1,
    STEP_WAKE_INIT = 3'd2,
    STEP_PRIME     = 3'd3,
    STEP_SCAN      = 3'd4,
    STEP_FINISH    = 3'd5,
    STEP_ADD       = 3'd6
  } step_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ADD,
    ACT_WAKE_INIT,
    ACT_PRIME,
    ACT_SCAN,
    ACT_FINISH
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_IS_ADD,
    COND_EMPTY,
    COND_SCAN_MORE
  } cond_t;

  // One control word: datapath action, jump condition and jump target.
  typedef struct packed {
    logic  idle;
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic no_start;
    logic is_add;
    logic empty;
    logic scan_more;
  } flags_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{idle: 1'b0, act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (s)
      STEP_IDLE:      w = '{idle: 1'b1, act: ACT_NONE, cond: COND_NO_START,
                            target: STEP_IDLE};
      STEP_DISPATCH:  w = '{idle: 1'b0, act: ACT_NONE, cond: COND_IS_ADD,
                            target: STEP_ADD};
      STEP_WAKE_INIT: w = '{idle: 1'b0, act: ACT_WAKE_INIT, cond: COND_EMPTY,
                            target: STEP_FINISH};
      STEP_PRIME:     w = '{idle: 1'b0, act: ACT_PRIME, cond: COND_NEVER,
                            target: STEP_IDLE};
      STEP_SCAN:      w = '{idle: 1'b0, act: ACT_SCAN, cond: COND_SCAN_MORE,
                            target: STEP_SCAN};
      STEP_FINISH:    w = '{idle: 1'b0, act: ACT_FINISH, cond: COND_ALWAYS,
                            target: STEP_IDLE};
      STEP_ADD:       w = '{idle: 1'b0, act: ACT_ADD, cond: COND_ALWAYS,
                            target: STEP_IDLE};
      default:        w = '{idle: 1'b0, act: ACT_NONE, cond: COND_ALWAYS,
                            target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/tes_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module tes_seq import tes_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  step_t step;
  step_t step_next;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = ucode(step);
  end

  always_comb begin
    take = 1'b0;
    unique case (ctrl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = flags.no_start;
      COND_IS_ADD:    take = flags.is_add;
      COND_EMPTY:     take = flags.empty;
      COND_SCAN_MORE: take = flags.scan_more;
      default:        take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step_t'(3'(step) + 3'd1);
  end

endmodule

>>> rtl/core/timed_event_slot_table.sv
// Add: busy through the dispatch and add steps; its result strobe is registered from add.
// Wake with N > 0 slots filled: busy through dispatch, wake-init, prime, a scan step per
// filled slot and finish; commands stream one per cycle at most, the last one (or the
// no-match result) strobed from finish; an empty table jumps from wake-init to finish.
// The rate is set by the slot memory's single read port: one slot compared per cycle.
// Reset empties the table at once (fill count to zero); the receiver cannot stall.
module timed_event_slot_table import tes_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t item,
  output logic     busy,
  output logic     strobe,
  output result_t  result
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  ctrl_t  ctrl;
  flags_t flags;

  in_item_t   item_q;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W-1:0] cmp_idx;
  slot_t      rd_data;
  slot_t      slot_mem [SLOT_COUNT];
  logic       held_valid;
  slot_t      held;
  logic       full;
  logic       match;
  logic       emit;
  result_t    result_next;

  tes_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign busy  = ~ctrl.idle;
  assign full  = (count == CNT_W'(SLOT_COUNT));
  assign match = (rd_data.minute == item_q.minute_value);

  always_comb begin
    flags.no_start  = ~start;
    flags.is_add    = (item_q.opcode == OP_ADD);
    flags.empty     = (count == '0);
    flags.scan_more = ((CNT_W'(cmp_idx) + CNT_W'(1)) != count);
  end

  // Slots fill from the bottom and never free, so the fill count is the free slot.
  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_ADD && !full) begin
      slot_mem[count[IDX_W-1:0]] <= '{light: item_q.light_number,
                                      minute: item_q.minute_value,
                                      turn_on: item_q.switch_on};
    end
    rd_data <= slot_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_ptr     <= '0;
      cmp_idx    <= '0;
      held_valid <= 1'b0;
    end else begin
      case (ctrl.act)
        ACT_ADD: begin
          if (!full) begin
            count <= count + CNT_W'(1);
          end
        end
        ACT_WAKE_INIT: begin
          rd_ptr     <= '0;
          cmp_idx    <= '0;
          held_valid <= 1'b0;
        end
        ACT_PRIME, ACT_SCAN: begin
          // advance the read pointer, hold it at the top slot
          if (rd_ptr != IDX_W'(SLOT_COUNT - 1)) begin
            rd_ptr <= rd_ptr + IDX_W'(1);
          end
          if (ctrl.act == ACT_SCAN) begin
            cmp_idx <= cmp_idx + IDX_W'(1);
            if (match) begin
              held_valid <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_SCAN && match) begin
      held <= rd_data;
    end
  end

  // A command is sent only once the next match or the end of the scan is seen.
  always_comb begin
    emit        = 1'b0;
    result_next = '{kind: KIND_ADD, accepted: 1'b0, command_light: 8'd0,
                    command_on: 1'b0, last: 1'b1};
    case (ctrl.act)
      ACT_ADD: begin
        emit                 = 1'b1;
        result_next.accepted = ~full;
      end
      ACT_SCAN: begin
        emit                      = match && held_valid;
        result_next.kind          = KIND_LIGHT;
        result_next.command_light = held.light;
        result_next.command_on    = held.turn_on;
        result_next.last          = 1'b0;
      end
      ACT_FINISH: begin
        emit = 1'b1;
        if (held_valid) begin
          result_next.kind          = KIND_LIGHT;
          result_next.command_light = held.light;
          result_next.command_on    = held.turn_on;
        end else begin
          result_next.kind = KIND_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

  a_strobe_from_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without work in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOT_COUNT))
    else $error("fill count beyond table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_add_fills: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind == KIND_ADD && result.accepted) |->
      (count == $past(count) + CNT_W'(1)))
    else $error("stored add did not advance fill count");

endmodule
